[src/adf_pkg.sv]
// Package for the aging duplicate filter: controller states, command and
// status structs between controller and datapath, opcodes and register codes.
// No dependencies.
package adf_pkg;

   // Opcodes of an input beat.
   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_PRUNE = 1'b1;

   // Configuration register indexes.
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_AGE_VIEWER = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_AGE_AGENT  = 1'b1;

   // Reset lifetime of an entry in microseconds, and the removal count ceiling.
   localparam logic [31:0] MAX_AGE_RESET = 32'd10000000;
   localparam logic [5:0]  REMOVED_MAX   = 6'd63;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_SCAN,
      ST_FINISH
   } adf_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic setup;
      logic scan;
      logic next_cat;
      logic finish;
   } adf_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_done;
      logic op_prune;
      logic last_cat;
      logic out_free;
   } adf_status_type;

endpackage

[src/adf_ctrl.sv]
// Controller state machine of the aging duplicate filter.
// Depends on adf_pkg for the state enum and the command and status structs.
module adf_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  adf_pkg::adf_status_type status,
   output adf_pkg::adf_cmd_type    cmd
);

   adf_pkg::adf_state_type state_ff;
   adf_pkg::adf_state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= adf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         adf_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = adf_pkg::ST_SETUP;
            end
         end
         adf_pkg::ST_SETUP: begin
            state_in = adf_pkg::ST_SCAN;
         end
         adf_pkg::ST_SCAN: begin
            if (status.scan_done) begin
               if (status.op_prune && !status.last_cat) begin
                  state_in = adf_pkg::ST_SETUP;
               end else begin
                  state_in = adf_pkg::ST_FINISH;
               end
            end
         end
         adf_pkg::ST_FINISH: begin
            if (status.out_free) begin
               state_in = adf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = adf_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs: commands and the input stall.
   always_comb begin
      cmd       = '0;
      req_stall = (state_ff != adf_pkg::ST_IDLE);
      unique case (state_ff)
         adf_pkg::ST_IDLE: begin
            cmd.load = req_valid;
         end
         adf_pkg::ST_SETUP: begin
            cmd.setup = 1'b1;
         end
         adf_pkg::ST_SCAN: begin
            cmd.scan     = 1'b1;
            cmd.next_cat = status.scan_done && status.op_prune && !status.last_cat;
         end
         adf_pkg::ST_FINISH: begin
            cmd.finish = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

[src/adf_datapath.sv]
// Datapath of the aging duplicate filter: item registers, per-category ring
// pointers and counts, key and time memories, scan logic and result register.
// Depends on adf_pkg for the command and status structs and constants.
module adf_datapath #(
   parameter int ENTRIES    = 16,
   parameter int CATEGORIES = 2,
   parameter int KEY_BITS   = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  adf_pkg::adf_cmd_type                cmd,
   output adf_pkg::adf_status_type             status,
   input  logic                                req_opcode,
   input  logic                                req_category,
   input  logic [31:0]                         req_message_key,
   input  logic [63:0]                         req_now_usec,
   input  logic                                csr_write_enable,
   input  logic [adf_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [31:0]                         csr_write_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_accepted,
   output logic                                rsp_evicted_oldest,
   output logic [5:0]                          rsp_removed_count
);

   localparam int SW    = $clog2(ENTRIES);
   localparam int CNTW  = $clog2(ENTRIES + 1);
   localparam int CW    = (CATEGORIES > 1) ? $clog2(CATEGORIES) : 1;
   localparam int AW    = CW + SW;
   localparam int DEPTH = 2 ** AW;
   localparam int SKW   = (KEY_BITS < 32) ? KEY_BITS : 32;
   localparam int OW    = CNTW + 1;

   // Configuration registers.
   logic [31:0] max_age_viewer_ff;
   logic [31:0] max_age_agent_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_age_viewer_ff <= adf_pkg::MAX_AGE_RESET;
         max_age_agent_ff  <= adf_pkg::MAX_AGE_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            adf_pkg::CSR_MAX_AGE_VIEWER: max_age_viewer_ff <= csr_write_data;
            adf_pkg::CSR_MAX_AGE_AGENT:  max_age_agent_ff  <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // Item and scan registers.
   logic            op_ff,        op_in;
   logic            cat_valid_ff, cat_valid_in;
   logic [CW-1:0]   scan_cat_ff,  scan_cat_in;
   logic [SKW-1:0]  key_ff,       key_in;
   logic [63:0]     now_ff,       now_in;
   logic [SW-1:0]   ptr_ff,       ptr_in;
   logic [CNTW-1:0] left_ff,      left_in;
   logic            pend_ff,      pend_in;
   logic            halt_ff,      halt_in;
   logic [5:0]      removed_ff,   removed_in;

   // Per-category ring state.
   logic [SW-1:0]   newest_ff [CATEGORIES];
   logic [SW-1:0]   newest_in [CATEGORIES];
   logic [CNTW-1:0] count_ff  [CATEGORIES];
   logic [CNTW-1:0] count_in  [CATEGORIES];

   // Result register.
   logic       rsp_valid_ff,    rsp_valid_in;
   logic       rsp_accepted_ff, rsp_accepted_in;
   logic       rsp_evicted_ff,  rsp_evicted_in;
   logic [5:0] rsp_removed_ff,  rsp_removed_in;

   // Memories and their registered read data.
   logic [SKW-1:0] key_mem  [DEPTH];
   logic [63:0]    time_mem [DEPTH];
   logic [SKW-1:0] rd_key_ff;
   logic [63:0]    rd_time_ff;

   // Helper signals.
   logic [CW-1:0]   sel_cat;
   logic [AW-1:0]   rd_addr;
   logic [AW-1:0]   wr_addr;
   logic [SW-1:0]   new_slot;
   logic [SW-1:0]   oldest_slot;
   logic [OW-1:0]   oldest_wide;
   logic [CNTW-1:0] cnt_less;
   logic [63:0]     age;
   logic [63:0]     age_limit;
   logic            issue;
   logic            store_now;
   logic            table_full;

   // A category beyond the table count is steered to table zero and masked.
   assign sel_cat = cat_valid_ff ? scan_cat_ff : '0;
   assign rd_addr = {sel_cat, ptr_ff};

   // Oldest slot of the selected ring: newest minus (count - 1), modulo ENTRIES.
   assign cnt_less = count_ff[sel_cat] - 1'b1;
   assign oldest_wide = (OW'(newest_ff[sel_cat]) >= OW'(cnt_less)) ?
                        (OW'(newest_ff[sel_cat]) - OW'(cnt_less)) :
                        (OW'(newest_ff[sel_cat]) + OW'(ENTRIES) - OW'(cnt_less));
   assign oldest_slot = oldest_wide[SW-1:0];

   assign new_slot = (newest_ff[sel_cat] == SW'(ENTRIES - 1)) ? '0 :
                     newest_ff[sel_cat] + 1'b1;
   assign wr_addr  = {sel_cat, new_slot};

   assign age       = now_ff - rd_time_ff;
   assign age_limit = (sel_cat == '0) ? 64'(max_age_viewer_ff) : 64'(max_age_agent_ff);
   assign issue     = (left_ff != '0) && !halt_ff;

   assign table_full = (count_ff[sel_cat] == CNTW'(ENTRIES));
   assign store_now  = cmd.finish && (op_ff == adf_pkg::OP_ADD) && cat_valid_ff && !halt_ff;

   // Next values of the datapath registers.
   always_comb begin
      op_in           = op_ff;
      cat_valid_in    = cat_valid_ff;
      scan_cat_in     = scan_cat_ff;
      key_in          = key_ff;
      now_in          = now_ff;
      ptr_in          = ptr_ff;
      left_in         = left_ff;
      pend_in         = pend_ff;
      halt_in         = halt_ff;
      removed_in      = removed_ff;
      newest_in       = newest_ff;
      count_in        = count_ff;
      rsp_accepted_in = rsp_accepted_ff;
      rsp_evicted_in  = rsp_evicted_ff;
      rsp_removed_in  = rsp_removed_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;

      // Capture the beat; a prune starts at the first table.
      if (cmd.load) begin
         op_in      = req_opcode;
         key_in     = req_message_key[SKW-1:0];
         now_in     = req_now_usec;
         removed_in = '0;
         if (req_opcode == adf_pkg::OP_ADD) begin
            cat_valid_in = (32'(req_category) < CATEGORIES);
            scan_cat_in  = CW'(req_category);
         end else begin
            cat_valid_in = 1'b1;
            scan_cat_in  = '0;
         end
      end

      // An add walks from the newest entry back, a prune from the oldest on.
      if (cmd.setup) begin
         ptr_in  = (op_ff == adf_pkg::OP_ADD) ? newest_ff[sel_cat] : oldest_slot;
         left_in = cat_valid_ff ? count_ff[sel_cat] : '0;
         pend_in = 1'b0;
         halt_in = 1'b0;
      end

      // Issue one read a cycle and check the data of the previous one.
      if (cmd.scan) begin
         pend_in = issue;
         if (issue) begin
            left_in = left_ff - 1'b1;
            if (op_ff == adf_pkg::OP_ADD) begin
               ptr_in = (ptr_ff == '0) ? SW'(ENTRIES - 1) : ptr_ff - 1'b1;
            end else begin
               ptr_in = (ptr_ff == SW'(ENTRIES - 1)) ? '0 : ptr_ff + 1'b1;
            end
         end
         if (pend_ff && !halt_ff) begin
            if (op_ff == adf_pkg::OP_ADD) begin
               if (rd_key_ff == key_ff) begin
                  halt_in = 1'b1;
               end
            end else if (age >= age_limit) begin
               count_in[sel_cat] = count_ff[sel_cat] - 1'b1;
               if (removed_ff != adf_pkg::REMOVED_MAX) begin
                  removed_in = removed_ff + 1'b1;
               end
            end else begin
               halt_in = 1'b1;
            end
         end
      end

      if (cmd.next_cat) begin
         scan_cat_in = scan_cat_ff + 1'b1;
      end

      // Store a new key and load the result register.
      if (store_now) begin
         newest_in[sel_cat] = new_slot;
         if (!table_full) begin
            count_in[sel_cat] = count_ff[sel_cat] + 1'b1;
         end
      end
      if (cmd.finish) begin
         rsp_valid_in    = 1'b1;
         rsp_accepted_in = store_now;
         rsp_evicted_in  = store_now && table_full;
         rsp_removed_in  = (op_ff == adf_pkg::OP_PRUNE) ? removed_ff : '0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         halt_ff      <= 1'b0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < CATEGORIES; c++) begin
            newest_ff[c] <= '0;
            count_ff[c]  <= '0;
         end
      end else begin
         pend_ff      <= pend_in;
         halt_ff      <= halt_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
         newest_ff    <= newest_in;
         count_ff     <= count_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff           <= op_in;
      cat_valid_ff    <= cat_valid_in;
      scan_cat_ff     <= scan_cat_in;
      key_ff          <= key_in;
      now_ff          <= now_in;
      ptr_ff          <= ptr_in;
      removed_ff      <= removed_in;
      rsp_accepted_ff <= rsp_accepted_in;
      rsp_evicted_ff  <= rsp_evicted_in;
      rsp_removed_ff  <= rsp_removed_in;
   end

   // Key and time memories: one write port, one registered read port each.
   always_ff @(posedge clock) begin
      if (store_now) begin
         key_mem[wr_addr]  <= key_ff;
         time_mem[wr_addr] <= now_ff;
      end
      rd_key_ff  <= key_mem[rd_addr];
      rd_time_ff <= time_mem[rd_addr];
   end

   assign status.scan_done = halt_ff || ((left_ff == '0) && !pend_ff);
   assign status.op_prune  = (op_ff == adf_pkg::OP_PRUNE);
   assign status.last_cat  = (scan_cat_ff == CW'(CATEGORIES - 1));
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_accepted       = rsp_accepted_ff;
   assign rsp_evicted_oldest = rsp_evicted_ff;
   assign rsp_removed_count  = rsp_removed_ff;

endmodule

[src/aging_duplicate_filter.sv]
// Aging duplicate filter, top level.
// Depends on adf_pkg, adf_ctrl and adf_datapath.
//
// Usage: the req channel carries one beat per operation (opcode, category,
// message key, current time); the rsp channel returns exactly one beat per
// request, in order. An add looks its key up in the table of its category and
// stores it as the newest entry if absent; a prune removes aged entries from
// the oldest end of every table. The csr port writes the two maximum ages and
// must only be used while the block is idle.
// Timing: one beat is handled at a time, the memories being read one entry a
// cycle. The next beat can be taken as soon as the result of the previous beat
// has been loaded into the output register.
// Reset empties every table and restores both maximum ages to ten seconds;
// stored keys and times need no clearing. A stalled result is held in the
// output register while the next request is accepted and worked on; that
// request finishes once the waiting result has been taken.
module aging_duplicate_filter #(
   parameter int ENTRIES    = 16,
   parameter int CATEGORIES = 2,
   parameter int KEY_BITS   = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_opcode,
   input  logic                                req_category,
   input  logic [31:0]                         req_message_key,
   input  logic [63:0]                         req_now_usec,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_accepted,
   output logic                                rsp_evicted_oldest,
   output logic [5:0]                          rsp_removed_count,
   input  logic                                csr_write_enable,
   input  logic [adf_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [31:0]                         csr_write_data
);

   adf_pkg::adf_cmd_type    cmd;
   adf_pkg::adf_status_type status;

   // Sequencer.
   adf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Tables, scan logic and result register.
   adf_datapath #(
      .ENTRIES    (ENTRIES),
      .CATEGORIES (CATEGORIES),
      .KEY_BITS   (KEY_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_opcode         (req_opcode),
      .req_category       (req_category),
      .req_message_key    (req_message_key),
      .req_now_usec       (req_now_usec),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_accepted       (rsp_accepted),
      .rsp_evicted_oldest (rsp_evicted_oldest),
      .rsp_removed_count  (rsp_removed_count)
   );

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the aging duplicate filter: a scoreboard class
// predicts every result beat; tasks drive the req and csr ports, a process rsp_stall.
// Depends on adf_pkg and aging_duplicate_filter.

localparam int TABLE_DEPTH    = 16;
localparam int CATEGORY_COUNT = 2;

// Table selected by an add beat.
localparam logic CAT_VIEWER = 1'b0;
localparam logic CAT_AGENT  = 1'b1;

typedef struct packed {
   logic       accepted;
   logic       evicted;
   logic [5:0] removed;
} dedup_verdict_type;

// Keeps its own copy of both key tables and predicts the verdict of each beat.
class dedup_scoreboard;
   logic [31:0]       keys   [CATEGORY_COUNT][TABLE_DEPTH];
   logic [63:0]       stamps [CATEGORY_COUNT][TABLE_DEPTH];
   int unsigned       newest [CATEGORY_COUNT];
   int unsigned       fill   [CATEGORY_COUNT];
   logic [31:0]       max_age[CATEGORY_COUNT];
   dedup_verdict_type verdicts[$];
   int unsigned       errors;

   function new();
      for (int c = 0; c < CATEGORY_COUNT; c++) begin
         newest[c]  = 0;
         fill[c]    = 0;
         max_age[c] = adf_pkg::MAX_AGE_RESET;
      end
      errors = 0;
   endfunction

   function void set_max_age(logic [adf_pkg::CSR_INDEX_BITS-1:0] index,
                             logic [31:0] value);
      if (index == adf_pkg::CSR_MAX_AGE_VIEWER) begin
         max_age[CAT_VIEWER] = value;
      end else if (index == adf_pkg::CSR_MAX_AGE_AGENT) begin
         max_age[CAT_AGENT] = value;
      end
   endfunction

   // Ring slot of the k-th newest entry of a table, k = 0 being the newest.
   function int unsigned ring_slot(int unsigned c, int unsigned k);
      return (newest[c] + TABLE_DEPTH - k) % TABLE_DEPTH;
   endfunction

   function int pending();
      return verdicts.size();
   endfunction

   // Works out the verdict of an accepted request beat and queues it.
   function void note_request(logic op, logic cat, logic [31:0] key, logic [63:0] now);
      dedup_verdict_type v;
      int unsigned       total;
      bit                seen;
      v     = '0;
      total = 0;
      seen  = 1'b0;
      if (op == adf_pkg::OP_PRUNE) begin
         // Each table is trimmed from its oldest end until a young entry is met.
         for (int c = 0; c < CATEGORY_COUNT; c++) begin
            while (fill[c] != 0 &&
                   now - stamps[c][ring_slot(c, fill[c] - 1)] >= {32'd0, max_age[c]}) begin
               fill[c]--;
               total++;
            end
         end
         v.removed = (total > adf_pkg::REMOVED_MAX) ? adf_pkg::REMOVED_MAX : total[5:0];
      end else begin
         for (int k = 0; k < fill[cat]; k++) begin
            if (keys[cat][ring_slot(cat, k)] == key) seen = 1'b1;
         end
         // A duplicate leaves the table, and the stored time, untouched.
         if (!seen) begin
            newest[cat]              = (newest[cat] + 1) % TABLE_DEPTH;
            keys[cat][newest[cat]]   = key;
            stamps[cat][newest[cat]] = now;
            if (fill[cat] < TABLE_DEPTH) begin
               fill[cat]++;
            end else begin
               v.evicted = 1'b1;
            end
            v.accepted = 1'b1;
         end
      end
      verdicts.push_back(v);
   endfunction

   // Compares a result beat with the oldest outstanding verdict.
   function void check_response(logic acc, logic ev, logic [5:0] rem);
      dedup_verdict_type want;
      if (verdicts.size() == 0) begin
         $error("unexpected result beat: accepted %0d evicted_oldest %0d removed_count %0d",
                acc, ev, rem);
         errors++;
      end else begin
         want = verdicts.pop_front();
         if (acc !== want.accepted) begin
            $error("accepted: expected %0d, actual %0d", want.accepted, acc);
            errors++;
         end
         if (ev !== want.evicted) begin
            $error("evicted_oldest: expected %0d, actual %0d", want.evicted, ev);
            errors++;
         end
         if (rem !== want.removed) begin
            $error("removed_count: expected %0d, actual %0d", want.removed, rem);
            errors++;
         end
      end
   endfunction
endclass

module tb_top;

   localparam int PHASES      = 6;
   localparam int PHASE_BEATS = 250;
   localparam int POOL_SIZE   = 24;
   localparam int HOLD_CYCLES = 400;

   logic                               clock;
   logic                               reset;
   logic                               req_valid;
   logic                               req_stall;
   logic                               req_opcode;
   logic                               req_category;
   logic [31:0]                        req_message_key;
   logic [63:0]                        req_now_usec;
   logic                               rsp_valid;
   logic                               rsp_stall;
   logic                               rsp_accepted;
   logic                               rsp_evicted_oldest;
   logic [5:0]                         rsp_removed_count;
   logic                               csr_write_enable;
   logic [adf_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [31:0]                        csr_write_data;

   // Set for a stretch with no idling on either side.
   bit quiet;
   // Asks the result side for one long hold-off.
   bit hold_rsp;

   dedup_scoreboard sb = new();

   aging_duplicate_filter DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_category       (req_category),
      .req_message_key    (req_message_key),
      .req_now_usec       (req_now_usec),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_accepted       (rsp_accepted),
      .rsp_evicted_oldest (rsp_evicted_oldest),
      .rsp_removed_count  (rsp_removed_count),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Any run that has not finished by now is hung.
   initial begin
      #4_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   // Both handshakes are sampled at the same edge that completes them.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            sb.note_request(req_opcode, req_category, req_message_key, req_now_usec);
         end
         if (rsp_valid && !rsp_stall) begin
            sb.check_response(rsp_accepted, rsp_evicted_oldest, rsp_removed_count);
         end
      end
   end

   // Result side: random stalls, or one long hold-off when asked.
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            rsp_stall <= !quiet && ($urandom_range(0, 99) < 16);
         end
      end
   end

   // Offers one request beat, after a random gap, and waits until it is taken.
   task automatic send_beat(input logic op, input logic cat, input logic [31:0] key,
                            input logic [63:0] now);
      while (!quiet && $urandom_range(0, 99) < 16) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_category    <= cat;
      req_message_key <= key;
      req_now_usec    <= now;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Stops offering and waits until every outstanding result has been taken.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // Writes both maximum ages, one register per edge; the block must be idle.
   task automatic program_max_ages(input logic [31:0] viewer_age,
                                   input logic [31:0] agent_age);
      csr_write_enable <= 1'b1;
      csr_index        <= adf_pkg::CSR_MAX_AGE_VIEWER;
      csr_write_data   <= viewer_age;
      @(posedge clock);
      sb.set_max_age(adf_pkg::CSR_MAX_AGE_VIEWER, viewer_age);
      csr_index        <= adf_pkg::CSR_MAX_AGE_AGENT;
      csr_write_data   <= agent_age;
      @(posedge clock);
      sb.set_max_age(adf_pkg::CSR_MAX_AGE_AGENT, agent_age);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      logic [31:0] viewer_ages[PHASES];
      logic [31:0] agent_ages[PHASES];
      logic [31:0] key_pool[POOL_SIZE];
      logic [63:0] stamp;
      logic [31:0] span;
      logic        op;
      logic [31:0] key;

      viewer_ages      = '{32'd0, 32'd1000, 32'hFFFF_FFFF,
                           32'd4000, 32'd600, adf_pkg::MAX_AGE_RESET};
      agent_ages       = '{32'hFFFF_FFFF, 32'd250, 32'd0,
                           32'd4000, 32'd90, adf_pkg::MAX_AGE_RESET};
      quiet            = 1'b0;
      hold_rsp         = 1'b0;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_opcode       <= adf_pkg::OP_ADD;
      req_category     <= CAT_VIEWER;
      req_message_key  <= '0;
      req_now_usec     <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= adf_pkg::CSR_MAX_AGE_VIEWER;
      csr_write_data   <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed beats at the reset ages: a duplicate that must not refresh its
      // time, separate tables, the age limit met exactly and missed by one,
      // a time stamp that wraps, and a table that overflows.
      send_beat(adf_pkg::OP_ADD, CAT_VIEWER, 32'h0000_0000, 64'd0);
      send_beat(adf_pkg::OP_ADD, CAT_VIEWER, 32'h0000_0000, 64'd5);
      send_beat(adf_pkg::OP_ADD, CAT_AGENT, 32'h0000_0000, 64'd5);
      send_beat(adf_pkg::OP_ADD, CAT_AGENT, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      send_beat(adf_pkg::OP_ADD, CAT_VIEWER, 32'hFFFF_FFFF, 64'd7);
      send_beat(adf_pkg::OP_PRUNE, CAT_VIEWER, 32'h0000_0000, 64'd9_999_999);
      send_beat(adf_pkg::OP_PRUNE, CAT_AGENT, 32'hFFFF_FFFF, 64'd10_000_000);
      send_beat(adf_pkg::OP_PRUNE, CAT_VIEWER, 32'h0000_0000, 64'd10_000_005);
      send_beat(adf_pkg::OP_ADD, CAT_AGENT, 32'hFFFF_FFFF, 64'd10_000_006);
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         send_beat(adf_pkg::OP_ADD, CAT_VIEWER, 32'hA5A5_0000 + i, 64'd10_000_020 + i);
      end
      send_beat(adf_pkg::OP_ADD, CAT_VIEWER, 32'hFFFF_FFFF, 64'd10_000_040);

      // A zero maximum age empties both tables on the next prune.
      drain();
      program_max_ages(32'd0, 32'd0);
      send_beat(adf_pkg::OP_PRUNE, CAT_AGENT, 32'h5A5A_5A5A, 64'd10_000_050);

      // Random phases: mostly adds drawn from a small key pool so that
      // duplicates, overflow and ageing all happen, with some stray keys
      // and time steps backwards as noise.
      for (int p = 0; p < PHASES; p++) begin
         drain();
         program_max_ages(viewer_ages[p], agent_ages[p]);
         span = ((viewer_ages[p] > agent_ages[p]) ? viewer_ages[p] : agent_ages[p]) >> 3;
         span = span + 32'd16;
         stamp = (p == 2) ? 64'hFFFF_FFFF_FFFF_FFFF - 64'd5000 : {$urandom, $urandom};
         for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;
         quiet = (p == 4);
         for (int n = 0; n < PHASE_BEATS; n++) begin
            if (p == 3 && n == 10) hold_rsp = 1'b1;
            if (p == 1 && n == PHASE_BEATS / 2) drain();
            op  = ($urandom_range(0, 99) < 22) ? adf_pkg::OP_PRUNE : adf_pkg::OP_ADD;
            key = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                             : $urandom;
            if ($urandom_range(0, 49) == 0) begin
               stamp = stamp - {32'd0, span} * 3;
            end else begin
               stamp = stamp + $urandom_range(0, span);
            end
            send_beat(op, 1'($urandom_range(0, 1)), key, stamp);
         end
      end
      quiet = 1'b0;

      drain();
      repeat (40) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

[sim.f]
src/adf_pkg.sv
src/adf_ctrl.sv
src/adf_datapath.sv
src/aging_duplicate_filter.sv
verif/tb_top.sv
